// ----- design/stable_priority_queue_macros.svh -----
// Assertion macros used by the queue datapath.
`ifndef STABLE_PRIORITY_QUEUE_MACROS_SVH
`define STABLE_PRIORITY_QUEUE_MACROS_SVH

`ifndef NO_ASSERTIONS

// Condition that must hold at every edge out of reset.
`define SPQ_ASSERT_ALWAYS(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Consequence in the same cycle.
`define SPQ_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequence in the next cycle.
`define SPQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define SPQ_ASSERT_ALWAYS(lbl, clk, rst_n, cond, msg)
`define SPQ_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg)
`define SPQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

// ----- design/spq_pkg.sv -----
`default_nettype none

package spq_pkg;

    // Default queue depth
    localparam int CAPACITY_DEF = 16;

    // Field widths
    localparam int ITEM_W   = 8;
    localparam int PRIO_W   = 16;
    localparam int COUNT_W  = 5;
    localparam int STATUS_W = 2;

    // Operation codes
    localparam logic CMD_PUSH = 1'b0;
    localparam logic CMD_POP  = 1'b1;

    // Status codes
    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

    // Controller to datapath commands
    typedef struct packed {
        logic capture;  // latch the request payload
        logic exec;     // update the cell row and the result register
    } t_dp_cmd;

endpackage

`default_nettype wire

// ----- design/spq_if.sv -----
`default_nettype none

// Request channel: one push or pop per transfer.
interface spq_req_if;
    logic                                valid;
    logic                                ready;
    logic                                cmd;
    logic [spq_pkg::ITEM_W-1:0]          item;
    logic signed [spq_pkg::PRIO_W-1:0]   priority_req;

    modport source (output valid, output cmd, output item, output priority_req,
                    input ready);
    modport sink   (input valid, input cmd, input item, input priority_req,
                    output ready);
endinterface

// Response channel: one result per request.
interface spq_rsp_if;
    logic                                valid;
    logic                                ready;
    logic [spq_pkg::ITEM_W-1:0]          popped_item;
    logic                                popped_valid;
    logic [spq_pkg::COUNT_W-1:0]         entry_count;
    logic [spq_pkg::STATUS_W-1:0]        status;

    modport source (output valid, output popped_item, output popped_valid,
                    output entry_count, output status, input ready);
    modport sink   (input valid, input popped_item, input popped_valid,
                    input entry_count, input status, output ready);
endinterface

`default_nettype wire

// ----- design/spq_ctrl.sv -----
`default_nettype none

module spq_ctrl (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    output logic                  o_in_ready,
    output logic                  o_out_valid,
    input  wire logic             i_out_ready,
    output spq_pkg::t_dp_cmd      o_cmd
);

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   w_out_free;

    // Result register is free when empty or being drained this cycle
    assign w_out_free = !r_out_valid || i_out_ready;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    // Next state and commands
    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid;
        o_cmd       = '0;
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_EXEC;
                end
            end
            S_EXEC: begin
                if (w_out_free) begin
                    o_cmd.exec  = 1'b1;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

`default_nettype wire

// ----- design/spq_dp.sv -----
`default_nettype none

`include "stable_priority_queue_macros.svh"

module spq_dp #(
    parameter int CAPACITY = spq_pkg::CAPACITY_DEF
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire spq_pkg::t_dp_cmd                    i_cmd,
    input  wire logic                                i_req_cmd,
    input  wire logic [spq_pkg::ITEM_W-1:0]          i_req_item,
    input  wire logic signed [spq_pkg::PRIO_W-1:0]   i_req_prio,
    output logic [spq_pkg::ITEM_W-1:0]               o_popped_item,
    output logic                                     o_popped_valid,
    output logic [spq_pkg::COUNT_W-1:0]              o_entry_count,
    output logic [spq_pkg::STATUS_W-1:0]             o_status
);

    localparam int CW = $clog2(CAPACITY + 1);

    // Latched request
    logic                                r_cmd;
    logic [spq_pkg::ITEM_W-1:0]          r_new_item;
    logic signed [spq_pkg::PRIO_W-1:0]   r_new_prio;

    // Sorted cell row, head at index 0
    logic signed [spq_pkg::PRIO_W-1:0]   r_prio [CAPACITY];
    logic [spq_pkg::ITEM_W-1:0]          r_item [CAPACITY];
    logic [CW-1:0]                       r_count, n_count;

    // Result register
    logic [spq_pkg::ITEM_W-1:0]          r_popped_item, n_popped_item;
    logic                                r_popped_valid, n_popped_valid;
    logic [spq_pkg::COUNT_W-1:0]         r_entry_count;
    logic [spq_pkg::STATUS_W-1:0]        r_status, n_status;

    logic                                w_push_ok;
    logic                                w_pop_ok;
    logic [CAPACITY-1:0]                 w_ge;

    // Request latch
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_cmd      <= i_req_cmd;
            r_new_item <= i_req_item;
            r_new_prio <= i_req_prio;
        end
    end

    // Operation decode and result
    always_comb begin
        w_push_ok      = 1'b0;
        w_pop_ok       = 1'b0;
        n_count        = r_count;
        n_popped_item  = '0;
        n_popped_valid = 1'b0;
        n_status       = spq_pkg::ST_OK;
        if (r_cmd == spq_pkg::CMD_PUSH) begin
            if (r_count >= CW'(CAPACITY)) begin
                n_status = spq_pkg::ST_FULL;
            end else begin
                w_push_ok = 1'b1;
                n_count   = r_count + 1'b1;
            end
        end else begin
            if (r_count == '0) begin
                n_status = spq_pkg::ST_EMPTY;
            end else begin
                w_pop_ok       = 1'b1;
                n_count        = r_count - 1'b1;
                n_popped_item  = r_item[0];
                n_popped_valid = 1'b1;
            end
        end
    end

    // Cells: keep when stored entry ranks ahead, load the new entry at the
    // first slot that does not, otherwise move down by one; pop moves up
    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        assign w_ge[i] = (CW'(i) < r_count) && (r_prio[i] >= r_new_prio);

        always_ff @(posedge i_clk) begin
            if (i_cmd.exec && w_push_ok && !w_ge[i]) begin
                if (i == 0) begin
                    r_prio[i] <= r_new_prio;
                    r_item[i] <= r_new_item;
                end else if (w_ge[(i == 0) ? 0 : i-1]) begin
                    r_prio[i] <= r_new_prio;
                    r_item[i] <= r_new_item;
                end else begin
                    r_prio[i] <= r_prio[(i == 0) ? 0 : i-1];
                    r_item[i] <= r_item[(i == 0) ? 0 : i-1];
                end
            end else if (i_cmd.exec && w_pop_ok && (i < CAPACITY-1)) begin
                r_prio[i] <= r_prio[(i < CAPACITY-1) ? i+1 : i];
                r_item[i] <= r_item[(i < CAPACITY-1) ? i+1 : i];
            end
        end
    end

    // Entry count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.exec) begin
            r_count <= n_count;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            r_popped_item  <= n_popped_item;
            r_popped_valid <= n_popped_valid;
            r_entry_count  <= spq_pkg::COUNT_W'(n_count);
            r_status       <= n_status;
        end
    end

    assign o_popped_item  = r_popped_item;
    assign o_popped_valid = r_popped_valid;
    assign o_entry_count  = r_entry_count;
    assign o_status       = r_status;

    // Checks
    `SPQ_ASSERT_ALWAYS(a_count_bound, i_clk, i_rst_n, r_count <= CW'(CAPACITY), "count over capacity")
    `SPQ_ASSERT_NEXT(a_push_grows, i_clk, i_rst_n, i_cmd.exec && w_push_ok, r_count == CW'($past(r_count) + 1'b1), "push did not grow count")
    `SPQ_ASSERT_NEXT(a_pop_result, i_clk, i_rst_n, i_cmd.exec && w_pop_ok, r_popped_valid && (r_status == spq_pkg::ST_OK), "pop result not flagged")
    `SPQ_ASSERT_IMPLY(a_ge_prefix, i_clk, i_rst_n, i_cmd.exec && !w_ge[0], w_ge == '0, "cell compares not a prefix")

endmodule

`default_nettype wire

// ----- design/stable_priority_queue.sv -----
// Stable bounded max-priority queue of byte items held in a sorted row of
// CAPACITY cells (head = highest priority, oldest among equals). S_IDLE takes
// a request transfer; in S_EXEC every cell compares its priority with the new
// one in parallel and the row shifts to insert or pop. A result waits in an
// output register, so the next request is taken while it is pending; the update
// stalls only while the previous result is still untaken. Reset clears the
// entry count and the control state; no clearing pass runs over the cells.
`default_nettype none

module stable_priority_queue #(
    parameter int CAPACITY = spq_pkg::CAPACITY_DEF
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    spq_req_if.sink     i_req,
    spq_rsp_if.source   o_rsp
);

    spq_pkg::t_dp_cmd w_cmd;

    spq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_req.valid),
        .o_in_ready  (i_req.ready),
        .o_out_valid (o_rsp.valid),
        .i_out_ready (o_rsp.ready),
        .o_cmd       (w_cmd)
    );

    spq_dp #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .i_req_cmd      (i_req.cmd),
        .i_req_item     (i_req.item),
        .i_req_prio     (i_req.priority_req),
        .o_popped_item  (o_rsp.popped_item),
        .o_popped_valid (o_rsp.popped_valid),
        .o_entry_count  (o_rsp.entry_count),
        .o_status       (o_rsp.status)
    );

endmodule

`default_nettype wire
